// ----- design/pmiw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmiw_pkg: shared types and constants of the periodic minimum image wrap
// payload structs, configuration bundle, pipeline item and helpers
// ----------------------------------------------------------------------------
package pmiw_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int SEARCH_RADIUS       = 1;
    localparam int RECIP_FRAC_BITS     = 22;
    localparam int BASIS_FRAC_BITS     = 10;
    localparam int COMP_W              = 21;
    localparam int REG_W               = 63;
    localparam int COUNT_LIMIT         = 32767;
    localparam int SEARCH_SPAN         = 2 * SEARCH_RADIUS + 1;
    localparam int NUM_CANDS           = SEARCH_SPAN * SEARCH_SPAN * SEARCH_SPAN;

    localparam logic [2:0] CFG_BASIS_FIRST  = 3'd0;
    localparam logic [2:0] CFG_BASIS_SECOND = 3'd1;
    localparam logic [2:0] CFG_BASIS_THIRD  = 3'd2;
    localparam logic [2:0] CFG_RECIP_FIRST  = 3'd3;
    localparam logic [2:0] CFG_RECIP_SECOND = 3'd4;
    localparam logic [2:0] CFG_RECIP_THIRD  = 3'd5;
    localparam logic [2:0] CFG_PERIODIC     = 3'd6;

    typedef struct packed {
        logic               command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [31:0] ref_z;
    } src_t;

    typedef struct packed {
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
        logic signed [31:0] disp_z;
        logic signed [31:0] diff_x;
        logic signed [31:0] diff_y;
        logic signed [31:0] diff_z;
        logic signed [15:0] image_first;
        logic signed [15:0] image_second;
        logic signed [15:0] image_third;
    } dst_t;

    typedef struct packed {
        logic [2:0][REG_W-1:0] basis;
        logic [2:0][REG_W-1:0] recip;
        logic [2:0]            mask;
    } cfg_t;

    typedef struct packed {
        logic             vld;
        logic             cmd;
        logic [2:0][32:0] u;
        logic [2:0][15:0] m;
        logic [2:0][15:0] n;
        logic [2:0][31:0] disp;
        logic [2:0][31:0] diff;
        logic [63:0]      len;
    } item_t;

    function automatic logic signed [COMP_W-1:0] comp_of(logic [REG_W-1:0] r, int c);
        return r[COMP_W*c +: COMP_W];
    endfunction

endpackage

// ----- design/pmiw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmiw_front: difference and cell count front end
// forms u = pos - ref, the reciprocal dot products and the rounded counts
// ----------------------------------------------------------------------------
module pmiw_front
    import pmiw_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  src_valid,
    input  src_t  src_data,
    input  cfg_t  cfg,
    output item_t item_o
);

    localparam int SH    = RECIP_FRAC_BITS + COORD_FRAC_BITS;
    localparam int DOT_W = 57;
    localparam logic signed [DOT_W-1:0] HALF = {{(DOT_W-1){1'b0}}, 1'b1} << (SH - 1);
    localparam logic signed [DOT_W-1:0] LIM  = DOT_W'(COUNT_LIMIT);

    logic                    vld_a_reg, vld_b_reg;
    logic                    cmd_a_reg, cmd_b_reg;
    logic [2:0][32:0]        u_a_reg, u_b_reg;
    logic signed [53:0]      prod_b_reg [3][3];
    item_t                   item_reg;

    logic [2:0][32:0]        u_a_next;
    logic signed [53:0]      prod_b_next [3][3];
    item_t                   item_next;

    always_comb
    begin
        u_a_next[0] = 33'($signed(src_data.pos_x)) - 33'($signed(src_data.ref_x));
        u_a_next[1] = 33'($signed(src_data.pos_y)) - 33'($signed(src_data.ref_y));
        u_a_next[2] = 33'($signed(src_data.pos_z)) - 33'($signed(src_data.ref_z));
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_b_next[r][k] = 54'(comp_of(cfg.recip[r], k)) * 54'($signed(u_a_reg[k]));
            end
        end
    end

    // rounded floor of the dot product, saturated, zero on open axes
    always_comb
    begin
        logic signed [DOT_W-1:0] dot;
        logic signed [DOT_W-1:0] q;
        item_next     = '0;
        item_next.vld = vld_b_reg;
        item_next.cmd = cmd_b_reg;
        item_next.u   = u_b_reg;
        for (int r = 0; r < 3; r++)
        begin
            dot = DOT_W'(prod_b_reg[r][0]) + DOT_W'(prod_b_reg[r][1])
                + DOT_W'(prod_b_reg[r][2]) + HALF;
            q = dot >>> SH;
            if (!cfg.mask[r])
                item_next.m[r] = '0;
            else if (q > LIM)
                item_next.m[r] = 16'(COUNT_LIMIT);
            else if (q < -LIM)
                item_next.m[r] = 16'(-COUNT_LIMIT);
            else
                item_next.m[r] = q[15:0];
            item_next.n[r] = item_next.m[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            item_reg  <= '0;
        end
        else if (en)
        begin
            vld_a_reg <= src_valid;
            vld_b_reg <= vld_a_reg;
            item_reg  <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_a_reg <= src_data.command;
            u_a_reg   <= u_a_next;
            cmd_b_reg <= cmd_a_reg;
            u_b_reg   <= u_a_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_b_reg[r][k] <= prod_b_next[r][k];
                end
            end
        end
    end

    assign item_o = item_reg;

endmodule

// ----- design/pmiw_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmiw_cell: one image candidate of the search chain
// evaluates displacement, wrapped difference and squared length, keeps best
// ----------------------------------------------------------------------------
module pmiw_cell
    import pmiw_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter bit IS_BASE         = 1'b0,
    parameter int DI              = 0,
    parameter int DJ              = 0,
    parameter int DK              = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  cfg_t  cfg,
    input  item_t item_i,
    output item_t item_o
);

    localparam int UP = (COORD_FRAC_BITS >= BASIS_FRAC_BITS) ?
                        (COORD_FRAC_BITS - BASIS_FRAC_BITS) : 0;
    localparam int DN = (COORD_FRAC_BITS < BASIS_FRAC_BITS) ?
                        (BASIS_FRAC_BITS - COORD_FRAC_BITS) : 0;
    localparam int WW = 40 + UP;
    localparam logic signed [WW:0] IMAX = (WW+1)'(32'h7fff_ffff);
    localparam logic signed [16:0] LIM  = 17'(COUNT_LIMIT);

    item_t                  it1_reg, it2_reg, it3_reg, it4_reg;
    logic [2:0][15:0]       n1_reg, n2_reg, n3_reg;
    logic                   skip1_reg, skip2_reg, skip3_reg;
    logic signed [36:0]     p1_reg [3][3];
    logic [2:0][31:0]       disp2_reg, diff2_reg, disp3_reg, diff3_reg;
    logic [2:0][61:0]       sq3_reg;

    logic [2:0][15:0]       n_next;
    logic                   skip_next;
    logic signed [36:0]     p_next [3][3];
    logic [2:0][31:0]       disp_next, diff_next;
    logic [2:0][61:0]       sq_next;
    item_t                  it4_next;

    // candidate count, saturated; command 0 or off-axis steps on open axes skip
    always_comb
    begin
        logic signed [16:0] c;
        for (int a = 0; a < 3; a++)
        begin
            c = $signed({item_i.m[a][15], item_i.m[a]})
              + $signed(17'((a == 0) ? DI : (a == 1) ? DJ : DK));
            if (IS_BASE)
                n_next[a] = item_i.m[a];
            else if (c > LIM)
                n_next[a] = 16'(COUNT_LIMIT);
            else if (c < -LIM)
                n_next[a] = 16'(-COUNT_LIMIT);
            else
                n_next[a] = c[15:0];
        end
        skip_next = !IS_BASE && (!item_i.cmd
                  || (DI != 0 && !cfg.mask[0])
                  || (DJ != 0 && !cfg.mask[1])
                  || (DK != 0 && !cfg.mask[2]));
        for (int c2 = 0; c2 < 3; c2++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                p_next[c2][a] = 37'(comp_of(cfg.basis[a], c2)) * 37'($signed(n_next[a]));
            end
        end
    end

    // displacement in coordinate format and wrapped difference, saturated
    always_comb
    begin
        logic signed [38:0] s;
        logic signed [39:0] neg;
        logic signed [WW-1:0] w;
        logic signed [WW:0] d;
        logic signed [WW:0] we;
        for (int c2 = 0; c2 < 3; c2++)
        begin
            s   = 39'(p1_reg[c2][0]) + 39'(p1_reg[c2][1]) + 39'(p1_reg[c2][2]);
            neg = -40'(s);
            if (DN == 0)
                w = WW'(neg) <<< UP;
            else
                w = WW'((neg + (40'sd1 <<< ((DN > 0) ? DN - 1 : 0))) >>> DN);
            we = (WW+1)'(w);
            d  = we + (WW+1)'($signed(it1_reg.u[c2]));
            if (we > IMAX)
                disp_next[c2] = 32'h7fff_ffff;
            else if (we < -IMAX)
                disp_next[c2] = 32'h8000_0001;
            else
                disp_next[c2] = we[31:0];
            if (d > IMAX)
                diff_next[c2] = 32'h7fff_ffff;
            else if (d < -IMAX)
                diff_next[c2] = 32'h8000_0001;
            else
                diff_next[c2] = d[31:0];
        end
    end

    always_comb
    begin
        logic signed [31:0] v;
        logic [31:0] mag;
        for (int c2 = 0; c2 < 3; c2++)
        begin
            v   = $signed(diff2_reg[c2]);
            mag = (v < 0) ? 32'(-v) : 32'(v);
            sq_next[c2] = 62'(mag[30:0]) * 62'(mag[30:0]);
        end
    end

    // strictly shorter wins, ties keep the earlier image
    always_comb
    begin
        logic [63:0] len;
        len = 64'(sq3_reg[0]) + 64'(sq3_reg[1]) + 64'(sq3_reg[2]);
        it4_next = it3_reg;
        if (IS_BASE || (!skip3_reg && len < it3_reg.len))
        begin
            it4_next.n    = n3_reg;
            it4_next.disp = disp3_reg;
            it4_next.diff = diff3_reg;
            it4_next.len  = len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it1_reg <= '0;
            it2_reg <= '0;
            it3_reg <= '0;
            it4_reg <= '0;
        end
        else if (en)
        begin
            it1_reg <= item_i;
            it2_reg <= it1_reg;
            it3_reg <= it2_reg;
            it4_reg <= it4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg    <= n_next;
            skip1_reg <= skip_next;
            for (int c2 = 0; c2 < 3; c2++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    p1_reg[c2][a] <= p_next[c2][a];
                end
            end
            n2_reg    <= n1_reg;
            skip2_reg <= skip1_reg;
            disp2_reg <= disp_next;
            diff2_reg <= diff_next;
            n3_reg    <= n2_reg;
            skip3_reg <= skip2_reg;
            disp3_reg <= disp2_reg;
            diff3_reg <= diff2_reg;
            sq3_reg   <= sq_next;
        end
    end

    assign item_o = it4_reg;

endmodule

// ----- design/periodic_minimum_image_wrap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_minimum_image_wrap: triclinic minimum image wrapping, fixed point
// front end for the cell counts, then a chain of image evaluation cells
// ----------------------------------------------------------------------------
// usage
// - src channel (src_valid/src_ready/src_data) takes one request per cycle
//   while src_ready is high: a command, a position and a reference point
// - dst channel (dst_valid/dst_ready/dst_data) gives one result per request,
//   in order: displacement, wrapped difference and image counts
// - cfg_we/cfg_index/cfg_data write the cell basis, reciprocal rows and the
//   periodic mask; write only while no request is in flight
// - throughput: one request per cycle, sustained, with dst_ready high
// - pipeline: the three front stages and the four stages of each of the 28
//   cells (the base image and the 27 neighbours)
// - every request walks through all cells; command 0 simply leaves the
//   neighbour cells inactive
// - reset clears the configuration, the valid flags and the item registers of
//   every stage and empties the pipeline; other datapath registers keep their value
// - a stall on dst freezes the whole pipeline; src_ready drops in the same
//   cycle, so nothing is lost and src may still push while dst is empty
// ----------------------------------------------------------------------------
module periodic_minimum_image_wrap
    import pmiw_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             src_valid,
    output logic             src_ready,
    input  src_t             src_data,
    output logic             dst_valid,
    input  logic             dst_ready,
    output dst_t             dst_data,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_data
);

    localparam int NCELL = NUM_CANDS + 1;

    cfg_t  cfg_reg;
    logic  en;
    item_t chain [NCELL+1];

    // configuration registers, written by the user only while idle; not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASIS_FIRST:  cfg_reg.basis[0] <= cfg_data;
                CFG_BASIS_SECOND: cfg_reg.basis[1] <= cfg_data;
                CFG_BASIS_THIRD:  cfg_reg.basis[2] <= cfg_data;
                CFG_RECIP_FIRST:  cfg_reg.recip[0] <= cfg_data;
                CFG_RECIP_SECOND: cfg_reg.recip[1] <= cfg_data;
                CFG_RECIP_THIRD:  cfg_reg.recip[2] <= cfg_data;
                CFG_PERIODIC:     cfg_reg.mask     <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    // the whole pipeline moves unless a finished result is held up
    assign en        = !chain[NCELL].vld || dst_ready;
    assign src_ready = en;

    pmiw_front #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (src_valid),
        .src_data  (src_data),
        .cfg       (cfg_reg),
        .item_o    (chain[0])
    );

    // cell 0 takes the base image, the others the neighbours in search order
    // (third axis outermost, first axis innermost)
    for (genvar t = 0; t < NCELL; t++)
    begin : g_cell
        localparam int CI = (t == 0) ? 0 : t - 1;
        pmiw_cell #(
            .COORD_FRAC_BITS(COORD_FRAC_BITS),
            .IS_BASE        (t == 0),
            .DI             ((t == 0) ? 0 : (CI % SEARCH_SPAN) - SEARCH_RADIUS),
            .DJ             ((t == 0) ? 0 : ((CI / SEARCH_SPAN) % SEARCH_SPAN) - SEARCH_RADIUS),
            .DK             ((t == 0) ? 0 : (CI / (SEARCH_SPAN * SEARCH_SPAN)) - SEARCH_RADIUS)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .cfg    (cfg_reg),
            .item_i (chain[t]),
            .item_o (chain[t+1])
        );
    end

    assign dst_valid             = chain[NCELL].vld;
    assign dst_data.disp_x       = chain[NCELL].disp[0];
    assign dst_data.disp_y       = chain[NCELL].disp[1];
    assign dst_data.disp_z       = chain[NCELL].disp[2];
    assign dst_data.diff_x       = chain[NCELL].diff[0];
    assign dst_data.diff_y       = chain[NCELL].diff[1];
    assign dst_data.diff_z       = chain[NCELL].diff[2];
    assign dst_data.image_first  = chain[NCELL].n[0];
    assign dst_data.image_second = chain[NCELL].n[1];
    assign dst_data.image_third  = chain[NCELL].n[2];

endmodule

// ----- verif/tb_periodic_minimum_image_wrap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_minimum_image_wrap: self-checking bench for the image wrapper
// drives requests through cubic, triclinic and extreme cells, checks every result
// against typed values or an in-bench fixed-point model of the wrap and search
// ----------------------------------------------------------------------------
module tb_periodic_minimum_image_wrap;
    import pmiw_pkg::*;

    localparam int  CLK_HALF    = 2;
    localparam int  SETTLE_CYC  = 130;      // extra wait once no result is owed
    localparam int  HOLD_CYC    = 400;      // long receiver hold-off
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SHOW_LIMIT  = 10;
    localparam longint ONE_COORD = 64'sd65536;

    typedef longint trip_t [3];

    typedef struct {
        src_t stim;
        bit   typed;                        // expected value written by hand
        dst_t want;
    } probe_row_t;

    logic       clk;
    logic       rst_n;
    logic       src_valid;
    logic       src_ready;
    src_t       src_data;
    logic       dst_valid;
    logic       dst_ready;
    dst_t       dst_data;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [REG_W-1:0] cfg_data;

    // bench copy of the configuration registers
    logic [REG_W-1:0] basis_cur [3];
    logic [REG_W-1:0] recip_cur [3];
    logic [2:0]       mask_cur;

    dst_t       image_q [$];               // results still owed by the block
    probe_row_t probe_tab [$];
    int         mismatches;
    int         stray_results;
    int         results_seen;
    int         requests_sent;
    int         search_requests;
    int         settings_used;
    int         cycles;
    int         stall_pct;
    bit         hold_pending;

    periodic_minimum_image_wrap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ---------------------------------------------------------------- model

    // signed 21-bit component c of a packed register
    function automatic longint vec_comp(logic [REG_W-1:0] r, int c);
        logic signed [COMP_W-1:0] f;
        f = r[COMP_W*c +: COMP_W];
        return longint'(f);
    endfunction

    function automatic longint sym_clamp(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // displacement and wrapped difference for counts n, returns squared length
    function automatic longint unsigned image_length(trip_t n, trip_t u,
                                                     output trip_t disp,
                                                     output trip_t diff);
        longint          a;
        longint          w;
        longint          d;
        longint unsigned mag;
        longint unsigned len;
        len = 0;
        for (int c = 0; c < 3; c++)
        begin
            a = vec_comp(basis_cur[0], c) * n[0] + vec_comp(basis_cur[1], c) * n[1]
              + vec_comp(basis_cur[2], c) * n[2];
            // Q.10 to Q.16 is an exact left shift
            w = (-a) <<< (COORD_FRAC_BITS_DEF - BASIS_FRAC_BITS);
            d = sym_clamp(u[c] + w, 64'sd2147483647);
            mag = longint'(d < 0 ? -d : d);
            disp[c] = sym_clamp(w, 64'sd2147483647);
            diff[c] = d;
            len += mag * mag;
        end
        return len;
    endfunction

    function automatic dst_t predict_image(src_t s);
        trip_t           u;
        trip_t           m;
        trip_t           best_n;
        trip_t           best_disp;
        trip_t           best_diff;
        trip_t           cand_n;
        trip_t           cand_disp;
        trip_t           cand_diff;
        int              rad [3];
        longint          dot;
        longint unsigned best_len;
        longint unsigned cand_len;
        int              sh;
        dst_t            r;
        sh = RECIP_FRAC_BITS + COORD_FRAC_BITS_DEF;
        u[0] = longint'(s.pos_x) - longint'(s.ref_x);
        u[1] = longint'(s.pos_y) - longint'(s.ref_y);
        u[2] = longint'(s.pos_z) - longint'(s.ref_z);
        for (int c = 0; c < 3; c++)
        begin
            dot = vec_comp(recip_cur[c], 0) * u[0] + vec_comp(recip_cur[c], 1) * u[1]
                + vec_comp(recip_cur[c], 2) * u[2];
            dot += 64'sd1 <<< (sh - 1);
            m[c] = mask_cur[c] ? sym_clamp(dot >>> sh, COUNT_LIMIT) : 0;
            best_n[c] = m[c];
            rad[c] = mask_cur[c] ? SEARCH_RADIUS : 0;
        end
        best_len = image_length(best_n, u, best_disp, best_diff);
        if (s.command)
        begin
            // third axis outermost, first innermost; only strictly shorter wins
            for (int k = -rad[2]; k <= rad[2]; k++)
                for (int j = -rad[1]; j <= rad[1]; j++)
                    for (int i = -rad[0]; i <= rad[0]; i++)
                    begin
                        cand_n[0] = sym_clamp(m[0] + i, COUNT_LIMIT);
                        cand_n[1] = sym_clamp(m[1] + j, COUNT_LIMIT);
                        cand_n[2] = sym_clamp(m[2] + k, COUNT_LIMIT);
                        cand_len = image_length(cand_n, u, cand_disp, cand_diff);
                        if (cand_len < best_len)
                        begin
                            best_len  = cand_len;
                            best_n    = cand_n;
                            best_disp = cand_disp;
                            best_diff = cand_diff;
                        end
                    end
        end
        r.disp_x       = best_disp[0][31:0];
        r.disp_y       = best_disp[1][31:0];
        r.disp_z       = best_disp[2][31:0];
        r.diff_x       = best_diff[0][31:0];
        r.diff_y       = best_diff[1][31:0];
        r.diff_z       = best_diff[2][31:0];
        r.image_first  = best_n[0][15:0];
        r.image_second = best_n[1][15:0];
        r.image_third  = best_n[2][15:0];
        return r;
    endfunction

    // ------------------------------------------------------------- checking

    task automatic check_result(dst_t got);
        dst_t   want;
        longint e [9];
        longint a [9];
        string  nm [9] = '{"disp_x", "disp_y", "disp_z", "diff_x", "diff_y", "diff_z",
                           "image_first", "image_second", "image_third"};
        want = image_q.pop_front();
        e = '{want.disp_x, want.disp_y, want.disp_z, want.diff_x, want.diff_y,
              want.diff_z, want.image_first, want.image_second, want.image_third};
        a = '{got.disp_x, got.disp_y, got.disp_z, got.diff_x, got.diff_y,
              got.diff_z, got.image_first, got.image_second, got.image_third};
        for (int f = 0; f < 9; f++)
        begin
            if (e[f] != a[f])
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("mismatch on result %0d, %s: expected %0d, got %0d",
                             results_seen, nm[f], e[f], a[f]);
            end
        end
    endtask

    // results are taken at the rising edge, from values settled since the fall
    always @(posedge clk)
    begin
        if (rst_n && dst_valid && dst_ready)
        begin
            if (image_q.size() == 0)
            begin
                stray_results++;
                if (stray_results <= SHOW_LIMIT)
                    $display("result with nothing expected: disp %0d %0d %0d",
                             dst_data.disp_x, dst_data.disp_y, dst_data.disp_z);
            end
            else
            begin
                check_result(dst_data);
            end
            results_seen++;
        end
    end

    // hard stop
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, image_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls at stall_pct, plus one long hold-off on request
    initial
    begin
        dst_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                dst_ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge clk);
            end
            dst_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // -------------------------------------------------------------- drivers

    task automatic write_reg(logic [2:0] idx, logic [REG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        // model follows the block; index 7 is not a register
        if (idx <= CFG_BASIS_THIRD)
            basis_cur[idx] = val;
        else if (idx <= CFG_RECIP_THIRD)
            recip_cur[idx - CFG_RECIP_FIRST] = val;
        else if (idx == CFG_PERIODIC)
            mask_cur = val[2:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [REG_W-1:0] pack_vec(int x, int y, int z);
        logic [COMP_W-1:0] fx;
        logic [COMP_W-1:0] fy;
        logic [COMP_W-1:0] fz;
        fx = x[COMP_W-1:0];
        fy = y[COMP_W-1:0];
        fz = z[COMP_W-1:0];
        return {fz, fy, fx};
    endfunction

    task automatic set_cell(logic [REG_W-1:0] b0, logic [REG_W-1:0] b1,
                            logic [REG_W-1:0] b2, logic [REG_W-1:0] r0,
                            logic [REG_W-1:0] r1, logic [REG_W-1:0] r2,
                            logic [2:0] mask);
        write_reg(CFG_BASIS_FIRST, b0);
        write_reg(CFG_BASIS_SECOND, b1);
        write_reg(CFG_BASIS_THIRD, b2);
        write_reg(CFG_RECIP_FIRST, r0);
        write_reg(CFG_RECIP_SECOND, r1);
        write_reg(CFG_RECIP_THIRD, r2);
        write_reg(CFG_PERIODIC, {60'd0, mask});
        settings_used++;
    endtask

    // cubic cell of integer side len (5..1023)
    task automatic set_cubic(int len, logic [2:0] mask);
        int side;
        int inv;
        side = len * 1024;
        inv  = (4194304 + len / 2) / len;
        set_cell(pack_vec(side, 0, 0), pack_vec(0, side, 0), pack_vec(0, 0, side),
                 pack_vec(inv, 0, 0), pack_vec(0, inv, 0), pack_vec(0, 0, inv), mask);
    endtask

    // a request held until accepted; the expectation is booked on acceptance
    task automatic offer_request(src_t s, bit typed, dst_t want);
        @(negedge clk);
        src_valid <= 1'b1;
        src_data  <= s;
        do
            @(posedge clk);
        while (!src_ready);
        image_q.push_back(typed ? want : predict_image(s));
        requests_sent++;
        if (s.command)
            search_requests++;
    endtask

    task automatic idle_cycles(int n);
        @(negedge clk);
        src_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // sender pause until every result is back, then let the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        src_valid <= 1'b0;
        while (image_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic int near_coord(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic src_t rand_request(int span);
        src_t s;
        int   sel;
        sel = $urandom_range(0, 15);
        s.command = 1'($urandom_range(0, 1));
        if (sel == 0)
        begin
            // full 32-bit noise reaches every bit and the saturation paths
            s.pos_x = $urandom; s.pos_y = $urandom; s.pos_z = $urandom;
            s.ref_x = $urandom; s.ref_y = $urandom; s.ref_z = $urandom;
        end
        else
        begin
            s.pos_x = near_coord(span); s.pos_y = near_coord(span);
            s.pos_z = near_coord(span);
            if (sel == 1)
            begin
                s.ref_x = s.pos_x; s.ref_y = s.pos_y; s.ref_z = s.pos_z;
            end
            else
            begin
                s.ref_x = near_coord(span); s.ref_y = near_coord(span);
                s.ref_z = near_coord(span);
            end
        end
        return s;
    endfunction

    task automatic random_phase(int n, int span, bit gaps);
        int   burst;
        dst_t none;
        burst = 0;
        none  = '0;
        for (int i = 0; i < n; i++)
        begin
            if (gaps && burst == 0)
            begin
                idle_cycles($urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
            offer_request(rand_request(span), 1'b0, none);
            if (burst > 0)
                burst--;
        end
    endtask

    function automatic src_t mk_req(bit cmd, int px, int py, int pz,
                                    int rx, int ry, int rz);
        src_t s;
        s.command = cmd;
        s.pos_x = px; s.pos_y = py; s.pos_z = pz;
        s.ref_x = rx; s.ref_y = ry; s.ref_z = rz;
        return s;
    endfunction

    // zero cell: no counts, no displacement, diff is the clamped difference
    function automatic dst_t mk_plain(int dx, int dy, int dz);
        dst_t r;
        r = '0;
        r.diff_x = dx; r.diff_y = dy; r.diff_z = dz;
        return r;
    endfunction

    task automatic add_row(src_t s, bit typed, dst_t want);
        probe_row_t row;
        row.stim  = s;
        row.typed = typed;
        row.want  = want;
        probe_tab.push_back(row);
    endtask

    task automatic run_probes(bit use_typed);
        foreach (probe_tab[i])
            offer_request(probe_tab[i].stim, use_typed && probe_tab[i].typed,
                          probe_tab[i].want);
    endtask

    // ----------------------------------------------------------------- main

    initial
    begin
        int   imax;
        int   imin;
        int   half;
        dst_t none;
        imax = 32'h7fffffff;
        imin = 32'h80000000;
        half = int'(5 * ONE_COORD);
        none = '0;

        rst_n        = 1'b0;
        src_valid    = 1'b0;
        src_data     = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        stall_pct    = 0;
        hold_pending = 1'b0;
        cycles       = 0;
        mismatches   = 0;
        stray_results   = 0;
        results_seen    = 0;
        requests_sent   = 0;
        search_requests = 0;
        settings_used   = 1;
        for (int i = 0; i < 3; i++)
        begin
            basis_cur[i] = '0;
            recip_cur[i] = '0;
        end
        mask_cur = '0;

        // directed rows; hand-written results hold for the all-zero cell
        add_row(mk_req(1'b0, 0, 0, 0, 0, 0, 0), 1'b1, mk_plain(0, 0, 0));
        add_row(mk_req(1'b1, imax, imax, imax, imin, imin, imin), 1'b1,
                mk_plain(imax, imax, imax));
        add_row(mk_req(1'b0, imin, imin, imin, imax, imax, imax), 1'b1,
                mk_plain(-imax, -imax, -imax));
        add_row(mk_req(1'b1, 65536, -65536, 1, 0, 0, 0), 1'b1,
                mk_plain(65536, -65536, 1));
        // exactly half a cell for side 10: a tie for the rounded count
        add_row(mk_req(1'b1, half, -half, half, 0, 0, 0), 1'b0, none);
        add_row(mk_req(1'b0, half - 1, 1 - half, 32768, 0, 0, 0), 1'b0, none);
        add_row(mk_req(1'b1, imax, imin, imax, 0, 0, 0), 1'b0, none);
        add_row(mk_req(1'b0, imin, imax, imin, 0, 0, 0), 1'b0, none);
        add_row(mk_req(1'b1, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                       32'h55555555, 32'haaaaaaaa, 32'h55555555), 1'b0, none);
        add_row(mk_req(1'b1, -1, -1, -1, 1, 1, 1), 1'b0, none);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers still at reset: nothing wraps
        run_probes(1'b1);
        wait_drained();

        // cubic side 10, all axes periodic, no stalls, back to back
        set_cubic(10, 3'b111);
        run_probes(1'b0);
        random_phase(250, 8 * 655360, 1'b0);
        wait_drained();

        // triclinic cell with rounded inverse, long hold-off at the start
        set_cell(pack_vec(10240, 0, 0), pack_vec(3072, 9216, 0), pack_vec(2048, 1024, 8192),
                 pack_vec(419430, -139810, -87381), pack_vec(0, 466034, -58254),
                 pack_vec(0, 0, 524288), 3'b111);
        stall_pct    = 30;
        hold_pending = 1'b1;
        random_phase(300, 4 * 655360, 1'b1);
        wait_drained();

        // same cell, second axis open, heavy stalls and a mid-phase pause
        write_reg(CFG_PERIODIC, {60'd0, 3'b101});
        settings_used++;
        stall_pct = 50;
        random_phase(150, 4 * 655360, 1'b1);
        wait_drained();
        random_phase(150, 1 << 29, 1'b1);
        wait_drained();

        // largest positive components: counts and outputs saturate
        set_cell(pack_vec(1048575, 1048575, 1048575),
                 pack_vec(1048575, 1048575, 1048575),
                 pack_vec(1048575, 1048575, 1048575),
                 pack_vec(1048575, 1048575, 1048575),
                 pack_vec(1048575, 1048575, 1048575),
                 pack_vec(1048575, 1048575, 1048575), 3'b111);
        stall_pct = 10;
        random_phase(250, 1 << 29, 1'b1);
        wait_drained();

        // most negative components
        set_cell(pack_vec(-1048576, -1048576, -1048576),
                 pack_vec(-1048576, -1048576, -1048576),
                 pack_vec(-1048576, -1048576, -1048576),
                 pack_vec(-1048576, -1048576, -1048576),
                 pack_vec(-1048576, -1048576, -1048576),
                 pack_vec(-1048576, -1048576, -1048576), 3'b011);
        stall_pct = 25;
        random_phase(250, 1 << 29, 1'b1);
        wait_drained();

        // smallest cubic cell, one axis periodic; index 7 must be ignored
        set_cubic(5, 3'b010);
        write_reg(3'd7, REG_W'({$urandom, $urandom}));
        stall_pct = 0;
        random_phase(250, 6 * 327680, 1'b1);
        wait_drained();

        // raw random registers, changed twice
        for (int p = 0; p < 2; p++)
        begin
            set_cell(REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}),
                     REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}),
                     REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}),
                     3'($urandom_range(0, 7)));
            stall_pct = $urandom_range(0, 60);
            random_phase(150, 1 << 28, 1'b1);
            wait_drained();
        end

        $display("%0d requests (%0d with image search) over %0d cell settings, %0d results",
                 requests_sent, search_requests, settings_used, results_seen);
        $display("%0d field mismatches, %0d unexpected results, %0d still owed",
                 mismatches, stray_results, image_q.size());
        if (mismatches == 0 && stray_results == 0 && image_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
